// File: sv/djmhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djmhp_pkg
// Shared types, constants and the CORDIC arctangent table of the de Jong
// map histogram peaks unit.
// ----------------------------------------------------------------------------
package djmhp_pkg;

   // Fixed-point format of coordinates and coefficients
   localparam int FRAC_BITS   = 16;
   localparam int COEF_W      = 24;
   localparam int COORD_W     = 20;
   localparam int START_W     = 17;
   localparam int COUNT_W     = 16;
   localparam int CSR_IDX_W   = 2;

   // CORDIC: 24 rotations, angles and vectors with 30 fraction bits
   localparam int CORDIC_STAGES = 24;
   localparam int ITER_W        = 5;
   localparam int CV_W          = 33;
   localparam int OUT_SHIFT     = 30 - FRAC_BITS;
   localparam logic signed [CV_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [30:0]     INV_TWO_PI  = 31'sd683565276;
   localparam logic [30:0]            HALF_PI     = 31'd1686629713;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_D     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_COUNT = 2'd2;

   // Configuration reset values
   localparam logic [COEF_W-1:0]  COEF_C_RESET     = 24'sd159091;
   localparam logic [COEF_W-1:0]  COEF_D_RESET     = -24'sd142684;
   localparam logic [COUNT_W-1:0] ITER_COUNT_RESET = 16'd10000;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic signed [COEF_W-1:0] param_a;
      logic signed [COEF_W-1:0] param_b;
      logic [START_W-1:0]       start_x;
      logic [START_W-1:0]       start_y;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] x_peak_count;
      logic [COUNT_W-1:0] y_peak_count;
   } rsp_payload_type;

   typedef struct packed {
      logic clear;
      logic update;
   } hist_cmd_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] x_peak;
      logic [COUNT_W-1:0] y_peak;
   } hist_stat_type;

   typedef enum logic [2:0] {
      TRIG_IDLE, TRIG_MUL1, TRIG_MUL2, TRIG_MUL3, TRIG_ROT, TRIG_OUT
   } trig_state_type;

   typedef enum logic [1:0] {
      HIST_IDLE, HIST_CLEAR, HIST_READ, HIST_WRITE
   } hist_state_type;

   typedef enum logic [2:0] {
      TOP_IDLE, TOP_CLEAR, TOP_TRIG, TOP_POINT, TOP_HIST, TOP_FINISH
   } top_state_type;

   // Arctangent of 2^-i with 30 fraction bits
   function automatic logic signed [CV_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
      logic signed [CV_W-1:0] r;
      case (i)
         5'd0:    r = 33'sd843314857;
         5'd1:    r = 33'sd497837829;
         5'd2:    r = 33'sd263043837;
         5'd3:    r = 33'sd133525159;
         5'd4:    r = 33'sd67021687;
         5'd5:    r = 33'sd33543516;
         5'd6:    r = 33'sd16775851;
         5'd7:    r = 33'sd8388437;
         5'd8:    r = 33'sd4194283;
         5'd9:    r = 33'sd2097149;
         5'd10:   r = 33'sd1048576;
         5'd11:   r = 33'sd524288;
         5'd12:   r = 33'sd262144;
         5'd13:   r = 33'sd131072;
         5'd14:   r = 33'sd65536;
         5'd15:   r = 33'sd32768;
         5'd16:   r = 33'sd16384;
         5'd17:   r = 33'sd8192;
         5'd18:   r = 33'sd4096;
         5'd19:   r = 33'sd2048;
         5'd20:   r = 33'sd1024;
         5'd21:   r = 33'sd512;
         5'd22:   r = 33'sd256;
         5'd23:   r = 33'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: sv/djmhp_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djmhp_trig
// Sine and cosine of coef*coord: three multiply stages form the quadrant and
// the reduced angle, then an iterative CORDIC does one rotation per cycle.
// ----------------------------------------------------------------------------
module djmhp_trig (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [djmhp_pkg::COEF_W-1:0]    coef,
   input  logic signed [djmhp_pkg::COORD_W-1:0]   coord,
   output logic                                   done,
   output logic signed [djmhp_pkg::COORD_W-1:0]   sin_out,
   output logic signed [djmhp_pkg::COORD_W-1:0]   cos_out
);
   import djmhp_pkg::*;

   trig_state_type state_ff, state_in;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic signed [COEF_W-1:0]  coef_ff, coef_in;
   logic signed [COORD_W-1:0] coord_ff, coord_in;
   logic signed [27:0]        angle_ff, angle_in;
   logic [31:0]               phase_ff, phase_in;
   logic signed [CV_W-1:0]    x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [COORD_W-1:0] sin_ff, sin_in, cos_ff, cos_in;
   logic                      done_ff, done_in;

   logic signed [43:0]     prod_angle;
   logic signed [58:0]     prod_phase;
   logic [60:0]            prod_z;
   logic signed [CV_W-1:0] dx, dy, cs, sn, cs_sh, sn_sh;

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TRIG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      iter_ff  <= iter_in;
      coef_ff  <= coef_in;
      coord_ff <= coord_in;
      angle_ff <= angle_in;
      phase_ff <= phase_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
   end

   // Sequence the multiplies and rotations
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      coef_in  = coef_ff;
      coord_in = coord_ff;
      angle_in = angle_ff;
      phase_in = phase_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      done_in  = 1'b0;

      prod_angle = coef_ff * coord_ff;
      prod_phase = angle_ff * INV_TWO_PI;
      prod_z     = 61'(phase_ff[29:0]) * 61'(HALF_PI);
      dx         = y_ff >>> iter_ff;
      dy         = x_ff >>> iter_ff;

      unique case (phase_ff[31:30])
         2'd0:    begin cs = x_ff;  sn = y_ff;  end
         2'd1:    begin cs = -y_ff; sn = x_ff;  end
         2'd2:    begin cs = -x_ff; sn = -y_ff; end
         default: begin cs = y_ff;  sn = -x_ff; end
      endcase
      cs_sh = cs >>> OUT_SHIFT;
      sn_sh = sn >>> OUT_SHIFT;

      unique case (state_ff)
         TRIG_IDLE: begin
            if (start) begin
               coef_in  = coef;
               coord_in = coord;
               state_in = TRIG_MUL1;
            end
         end
         TRIG_MUL1: begin
            angle_in = prod_angle[43:16];
            state_in = TRIG_MUL2;
         end
         TRIG_MUL2: begin
            phase_in = prod_phase[47:16];
            state_in = TRIG_MUL3;
         end
         TRIG_MUL3: begin
            z_in     = {2'b00, prod_z[60:30]};
            x_in     = CORDIC_GAIN;
            y_in     = '0;
            iter_in  = '0;
            state_in = TRIG_ROT;
         end
         TRIG_ROT: begin
            if (!z_ff[CV_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_q30(iter_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_q30(iter_ff);
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(CORDIC_STAGES - 1)) state_in = TRIG_OUT;
         end
         TRIG_OUT: begin
            sin_in   = sn_sh[COORD_W-1:0];
            cos_in   = cs_sh[COORD_W-1:0];
            done_in  = 1'b1;
            state_in = TRIG_IDLE;
         end
         default: state_in = TRIG_IDLE;
      endcase
   end

   assign done    = done_ff;
   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// File: sv/djmhp_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djmhp_hist
// Two bin-count memories with a clearing sweep, a read-modify-write update
// of one bin per axis, and the running peak count of each axis.
// ----------------------------------------------------------------------------
module djmhp_hist #(
   parameter int HIST_BINS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  djmhp_pkg::hist_cmd_type       cmd,
   input  logic [$clog2(HIST_BINS)-1:0]  x_bin,
   input  logic [$clog2(HIST_BINS)-1:0]  y_bin,
   output djmhp_pkg::hist_stat_type      stat
);
   import djmhp_pkg::*;

   localparam int AW = $clog2(HIST_BINS);

   logic [COUNT_W-1:0] x_mem [HIST_BINS];
   logic [COUNT_W-1:0] y_mem [HIST_BINS];

   hist_state_type state_ff, state_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      xa_ff, xa_in, ya_ff, ya_in;
   logic [COUNT_W-1:0] xpk_ff, xpk_in, ypk_ff, ypk_in;
   logic [COUNT_W-1:0] x_rd_ff, y_rd_ff;

   logic               we, done;
   logic [AW-1:0]      x_wa, y_wa;
   logic [COUNT_W-1:0] x_wd, y_wd, x_next, y_next;

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HIST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      xa_ff  <= xa_in;
      ya_ff  <= ya_in;
      xpk_ff <= xpk_in;
      ypk_ff <= ypk_in;
   end

   // Bin memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         x_mem[x_wa] <= x_wd;
         y_mem[y_wa] <= y_wd;
      end
      x_rd_ff <= x_mem[xa_ff];
      y_rd_ff <= y_mem[ya_ff];
   end

   // Sweep, read and write back
   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      xa_in    = xa_ff;
      ya_in    = ya_ff;
      xpk_in   = xpk_ff;
      ypk_in   = ypk_ff;
      we       = 1'b0;
      done     = 1'b0;
      x_wa     = ptr_ff;
      y_wa     = ptr_ff;
      x_wd     = '0;
      y_wd     = '0;
      x_next   = (x_rd_ff == COUNT_MAX) ? x_rd_ff : x_rd_ff + 1'b1;
      y_next   = (y_rd_ff == COUNT_MAX) ? y_rd_ff : y_rd_ff + 1'b1;

      unique case (state_ff)
         HIST_IDLE: begin
            if (cmd.clear) begin
               ptr_in   = '0;
               xpk_in   = '0;
               ypk_in   = '0;
               state_in = HIST_CLEAR;
            end else if (cmd.update) begin
               xa_in    = x_bin;
               ya_in    = y_bin;
               state_in = HIST_READ;
            end
         end
         HIST_CLEAR: begin
            we     = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == AW'(HIST_BINS - 1)) begin
               done     = 1'b1;
               state_in = HIST_IDLE;
            end
         end
         HIST_READ: begin
            state_in = HIST_WRITE;
         end
         HIST_WRITE: begin
            we   = 1'b1;
            x_wa = xa_ff;
            y_wa = ya_ff;
            x_wd = x_next;
            y_wd = y_next;
            if (x_next > xpk_ff) xpk_in = x_next;
            if (y_next > ypk_ff) ypk_in = y_next;
            done     = 1'b1;
            state_in = HIST_IDLE;
         end
         default: state_in = HIST_IDLE;
      endcase
   end

   assign stat.done   = done;
   assign stat.x_peak = xpk_ff;
   assign stat.y_peak = ypk_ff;

endmodule

// File: sv/de_jong_map_histogram_peaks_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// de_jong_map_histogram_peaks_unit
// Runs the de Jong map from a start point and returns the peak bin count of
// the x and y coordinate histograms.
// ----------------------------------------------------------------------------
// A transaction first sweeps the histogram memories clear, then each map step
// runs the four sine/cosine units (three multiply stages, 24 CORDIC rotations,
// output, result register), followed by one point update and a
// read-modify-write of both histogram memories. A new request is taken once
// the previous result has been moved into the output register.
module de_jong_map_histogram_peaks_unit #(
   parameter int HIST_BINS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  djmhp_pkg::req_payload_type            req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output djmhp_pkg::rsp_payload_type            rsp_data,
   input  logic                                  csr_we,
   input  logic [djmhp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [djmhp_pkg::COEF_W-1:0]          csr_wdata
);
   import djmhp_pkg::*;

   localparam int AW        = $clog2(HIST_BINS);
   localparam int BinScale  = HIST_BINS / 4 - 1;
   localparam int BinCenter = HIST_BINS / 2;
   localparam int BW        = COORD_W + 13;

   top_state_type state_ff, state_in;

   logic signed [COEF_W-1:0]  coef_c_ff, coef_d_ff;
   logic [COUNT_W-1:0]        iter_count_ff;
   logic signed [COEF_W-1:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [COUNT_W-1:0]        steps_ff, steps_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_ff, rsp_in;

   logic                      accept, trig_start;
   logic                      done_ay, done_bx, done_cx, done_dy;
   logic signed [COORD_W-1:0] sin_ay, cos_bx, sin_cx, cos_dy;
   logic signed [COORD_W:0]   nx, ny;
   logic signed [BW-1:0]      xb_full, yb_full;
   logic [AW-1:0]             x_bin, y_bin;
   hist_cmd_type              hcmd;
   hist_stat_type             hstat;

   // Saturate a new coordinate to the point register range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > (COORD_W + 1)'((1 <<< (COORD_W - 1)) - 1)) r = {1'b0, {(COORD_W-1){1'b1}}};
      else if (v < -(COORD_W + 1)'(1 <<< (COORD_W - 1))) r = {1'b1, {(COORD_W-1){1'b0}}};
      else r = v[COORD_W-1:0];
      return r;
   endfunction

   // Map a coordinate to its clamped histogram bin
   function automatic logic [AW-1:0] bin_of(input logic signed [COORD_W-1:0] v);
      logic signed [BW-1:0] p;
      logic signed [BW-1:0] b;
      logic [AW-1:0]        r;
      p = BW'(v) * BW'(BinScale);
      b = (p >>> FRAC_BITS) + BW'(BinCenter);
      if (b < 0) r = '0;
      else if (b > BW'(HIST_BINS - 1)) r = AW'(HIST_BINS - 1);
      else r = b[AW-1:0];
      return r;
   endfunction

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_c_ff     <= COEF_C_RESET;
         coef_d_ff     <= COEF_D_RESET;
         iter_count_ff <= ITER_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_C:     coef_c_ff     <= csr_wdata;
            CSR_COEF_D:     coef_d_ff     <= csr_wdata;
            CSR_ITER_COUNT: iter_count_ff <= csr_wdata[COUNT_W-1:0];
            default:        ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      steps_ff <= steps_in;
      rsp_ff   <= rsp_in;
   end

   assign accept = req_valid && !req_stall;
   assign nx     = (COORD_W + 1)'(sin_ay) - (COORD_W + 1)'(cos_bx);
   assign ny     = (COORD_W + 1)'(sin_cx) - (COORD_W + 1)'(cos_dy);
   assign x_bin  = bin_of(px_ff);
   assign y_bin  = bin_of(py_ff);

   // Step sequencer
   always_comb begin
      state_in     = state_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      steps_in     = steps_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      trig_start   = 1'b0;
      hcmd.clear   = 1'b0;
      hcmd.update  = 1'b0;

      unique case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               pa_in      = req_data.param_a;
               pb_in      = req_data.param_b;
               px_in      = COORD_W'(req_data.start_x);
               py_in      = COORD_W'(req_data.start_y);
               steps_in   = iter_count_ff;
               hcmd.clear = 1'b1;
               state_in   = TOP_CLEAR;
            end
         end
         TOP_CLEAR: begin
            if (hstat.done) begin
               if (steps_ff == '0) begin
                  state_in = TOP_FINISH;
               end else begin
                  trig_start = 1'b1;
                  state_in   = TOP_TRIG;
               end
            end
         end
         TOP_TRIG: begin
            if (done_ay) begin
               px_in    = sat_coord(nx);
               py_in    = sat_coord(ny);
               state_in = TOP_POINT;
            end
         end
         TOP_POINT: begin
            hcmd.update = 1'b1;
            state_in    = TOP_HIST;
         end
         TOP_HIST: begin
            if (hstat.done) begin
               steps_in = steps_ff - 1'b1;
               if (steps_ff == COUNT_W'(1)) begin
                  state_in = TOP_FINISH;
               end else begin
                  trig_start = 1'b1;
                  state_in   = TOP_TRIG;
               end
            end
         end
         TOP_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.x_peak_count = hstat.x_peak;
               rsp_in.y_peak_count = hstat.y_peak;
               rsp_valid_in        = 1'b1;
               state_in            = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   // Four sine/cosine units, all started together
   djmhp_trig u_trig_ay (
      .clock(clock), .reset(reset), .start(trig_start), .coef(pa_ff), .coord(py_ff),
      .done(done_ay), .sin_out(sin_ay), .cos_out()
   );
   djmhp_trig u_trig_bx (
      .clock(clock), .reset(reset), .start(trig_start), .coef(pb_ff), .coord(px_ff),
      .done(done_bx), .sin_out(), .cos_out(cos_bx)
   );
   djmhp_trig u_trig_cx (
      .clock(clock), .reset(reset), .start(trig_start), .coef(coef_c_ff), .coord(px_ff),
      .done(done_cx), .sin_out(sin_cx), .cos_out()
   );
   djmhp_trig u_trig_dy (
      .clock(clock), .reset(reset), .start(trig_start), .coef(coef_d_ff), .coord(py_ff),
      .done(done_dy), .sin_out(), .cos_out(cos_dy)
   );

   djmhp_hist #(.HIST_BINS(HIST_BINS)) u_hist (
      .clock(clock), .reset(reset), .cmd(hcmd), .x_bin(x_bin), .y_bin(y_bin), .stat(hstat)
   );

   assign req_stall = (state_ff != TOP_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // The four trig units run in lockstep
   a_trig_lockstep: assert property (@(posedge clock) disable iff (reset)
      (done_ay == done_bx) && (done_ay == done_cx) && (done_ay == done_dy))
      else $error("trig units out of step");

   // Trig results arrive only while a map step is waiting for them
   a_trig_done_state: assert property (@(posedge clock) disable iff (reset)
      done_ay |-> state_ff == TOP_TRIG)
      else $error("trig result outside a map step");

   // Histogram completions arrive only during a clear or an update
   a_hist_done_state: assert property (@(posedge clock) disable iff (reset)
      hstat.done |-> (state_ff == TOP_CLEAR || state_ff == TOP_HIST))
      else $error("histogram done in wrong state");

   // An accepted transaction starts the clearing sweep
   a_accept_clear: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == TOP_CLEAR)
      else $error("accepted request did not start clearing");
`endif

endmodule

// File: bench/djmhp_peak_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djmhp_peak_checker
// Watches the request, response and register ports of the de Jong histogram
// peaks unit. It computes the x/y peak counts of every accepted request and
// compares each response with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module djmhp_peak_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  djmhp_pkg::req_payload_type         req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  djmhp_pkg::rsp_payload_type         rsp_data,
   input  logic                               csr_we,
   input  logic [djmhp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [djmhp_pkg::COEF_W-1:0]       csr_wdata,
   output int                                 error_count,
   output int                                 peaks_pending
);
   import djmhp_pkg::*;

   localparam int  BINS    = 256;
   localparam int  STAGES  = 24;
   localparam longint GAIN_Q30     = 64'd652032874;
   localparam longint INV_TURN_Q32 = 64'd683565276;
   localparam longint QUARTER_Q30  = 64'd1686629713;
   localparam longint ARCTAN_Q30 [STAGES] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

   logic signed [COEF_W-1:0] model_coef_c;
   logic signed [COEF_W-1:0] model_coef_d;
   logic [COUNT_W-1:0]       model_iterations;
   rsp_payload_type          peak_queue[$];

   // sin and cos (16 fraction bits) of the angle coef*coord
   function automatic void sincos_q16(input longint coef, input longint coord,
                                      output longint sin_v, output longint cos_v);
      longint angle;
      longint unsigned turn;
      logic [31:0] phase;
      longint cx, cy, cz, dx, dy, cs, sn;
      angle = (coef * coord) >>> FRAC_BITS;
      turn  = angle * INV_TURN_Q32;
      phase = turn[47:16];
      cz = (longint'(phase[29:0]) * QUARTER_Q30) >>> 30;
      cx = GAIN_Q30;
      cy = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cz >= 0) begin
            cx -= dx; cy += dy; cz -= ARCTAN_Q30[i];
         end else begin
            cx += dx; cy -= dy; cz += ARCTAN_Q30[i];
         end
      end
      case (phase[31:30])
         2'd0: begin cs = cx;  sn = cy;  end
         2'd1: begin cs = -cy; sn = cx;  end
         2'd2: begin cs = -cx; sn = -cy; end
         default: begin cs = cy; sn = -cx; end
      endcase
      sin_v = sn >>> (30 - FRAC_BITS);
      cos_v = cs >>> (30 - FRAC_BITS);
   endfunction

   function automatic longint clamp_coord(input longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   function automatic int bin_index(input longint v);
      longint b;
      b = ((v * (BINS / 4 - 1)) >>> FRAC_BITS) + BINS / 2;
      if (b < 0) return 0;
      if (b > BINS - 1) return BINS - 1;
      return int'(b);
   endfunction

   // Run the map over one request and return both histogram peaks
   function automatic rsp_payload_type de_jong_peaks(input req_payload_type req);
      int x_hist[BINS];
      int y_hist[BINS];
      int x_peak, y_peak, bx, by;
      longint px, py, nx, ny, s1, c1, s2, c2;
      rsp_payload_type r;
      x_hist = '{default: 0};
      y_hist = '{default: 0};
      x_peak = 0;
      y_peak = 0;
      px = longint'(req.start_x);
      py = longint'(req.start_y);
      for (int n = 0; n < int'(model_iterations); n++) begin
         sincos_q16(longint'(req.param_a), py, s1, c1);
         sincos_q16(longint'(req.param_b), px, s2, c2);
         nx = s1 - c2;
         sincos_q16(longint'(model_coef_c), px, s1, c1);
         sincos_q16(longint'(model_coef_d), py, s2, c2);
         ny = s1 - c2;
         px = clamp_coord(nx);
         py = clamp_coord(ny);
         bx = bin_index(px);
         by = bin_index(py);
         if (x_hist[bx] < 65535) x_hist[bx]++;
         if (y_hist[by] < 65535) y_hist[by]++;
         if (x_hist[bx] > x_peak) x_peak = x_hist[bx];
         if (y_hist[by] > y_peak) y_peak = y_hist[by];
      end
      r.x_peak_count = x_peak[15:0];
      r.y_peak_count = y_peak[15:0];
      return r;
   endfunction

   // Track registers, predict on request, compare on response
   always @(posedge clock) begin
      rsp_payload_type want;
      int              mismatches;
      mismatches = 0;
      if (reset) begin
         model_coef_c     <= COEF_C_RESET;
         model_coef_d     <= COEF_D_RESET;
         model_iterations <= ITER_COUNT_RESET;
         peak_queue.delete();
         error_count      <= 0;
         peaks_pending    <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COEF_C:     model_coef_c <= csr_wdata;
               CSR_COEF_D:     model_coef_d <= csr_wdata;
               CSR_ITER_COUNT: model_iterations <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            peak_queue.push_back(de_jong_peaks(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (peak_queue.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual x=%0d y=%0d",
                        $time, rsp_data.x_peak_count, rsp_data.y_peak_count);
               mismatches++;
            end else begin
               want = peak_queue.pop_front();
               if (want.x_peak_count !== rsp_data.x_peak_count) begin
                  $display("%0t: x_peak_count expected %0d actual %0d", $time,
                           want.x_peak_count, rsp_data.x_peak_count);
                  mismatches++;
               end
               if (want.y_peak_count !== rsp_data.y_peak_count) begin
                  $display("%0t: y_peak_count expected %0d actual %0d", $time,
                           want.y_peak_count, rsp_data.y_peak_count);
                  mismatches++;
               end
            end
         end
         error_count   <= error_count + mismatches;
         peaks_pending <= peak_queue.size();
      end
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests and register writes into the de Jong histogram peaks unit
// with random idle and stall patterns; a checker beside the unit predicts
// and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import djmhp_pkg::*;

   localparam longint CYCLE_LIMIT = 40000000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_data;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [COEF_W-1:0]      csr_wdata;
   int                     error_count;
   int                     peaks_pending;
   int                     send_idle;
   int                     recv_idle;
   int                     hold_off;
   longint                 cycle_count;

   de_jong_map_histogram_peaks_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   djmhp_peak_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .peaks_pending(peaks_pending));

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stall the response side at random, or hold off for a counted stretch
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_stall = 1'b1;
            hold_off  = hold_off - 1;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle);
         end
      end
   end

   // Abort on a hung run
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("de_jong_map_histogram_peaks_unit test failed");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // Wait for all outstanding responses, then settle before touching registers
   task automatic drain_results();
      req_valid = 1'b0;
      while (peaks_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send_point(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
                             input logic [START_W-1:0] sx, input logic [START_W-1:0] sy);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_data.param_a = a;
      req_data.param_b = b;
      req_data.start_x = sx;
      req_data.start_y = sy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [COEF_W-1:0] rand_coef();
      if ($urandom_range(9) == 0) return COEF_W'($urandom);
      return COEF_W'(int'($urandom_range(400000)) - 200000);
   endfunction

   function automatic logic [START_W-1:0] rand_start();
      if ($urandom_range(9) == 0) return START_W'($urandom);
      return START_W'($urandom_range(65536));
   endfunction

   task automatic random_phase(input int items);
      write_csr(CSR_COEF_C, rand_coef());
      write_csr(CSR_COEF_D, rand_coef());
      write_csr(CSR_ITER_COUNT, COEF_W'($urandom_range(24, 1)));
      for (int n = 0; n < items; n++)
         send_point(rand_coef(), rand_coef(), rand_start(), rand_start());
      drain_results();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle = 27;
      recv_idle = 57;
      hold_off  = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: zero steps, one step, field extremes, coefficient extremes
      write_csr(CSR_ITER_COUNT, 24'd0);
      send_point(24'h800000, 24'h7FFFFF, 17'd65536, 17'd0);
      drain_results();
      write_csr(CSR_ITER_COUNT, 24'd1);
      write_csr(CSR_COEF_C, 24'h7FFFFF);
      write_csr(CSR_COEF_D, 24'h800000);
      send_point(24'h800000, 24'h800000, 17'd0, 17'd0);
      send_point(24'h7FFFFF, 24'h7FFFFF, 17'd65536, 17'd65536);
      send_point(24'h000000, 24'h000000, 17'd65535, 17'd1);
      send_point(24'hFFFFFF, 24'h000001, 17'h1FFFF, 17'h0AAAA);
      drain_results();
      write_csr(CSR_ITER_COUNT, 24'd8);
      write_csr(CSR_COEF_C, 24'h000000);
      write_csr(CSR_COEF_D, 24'hFFFFFF);
      write_csr(CSR_UNMAPPED, 24'h123456);
      send_point(24'd155189, -24'sd149264, 17'd32768, 17'd49152);
      send_point(24'h800000, 24'h7FFFFF, 17'h15555, 17'h1FFFF);
      drain_results();
      write_csr(CSR_COEF_C, COEF_C_RESET);
      write_csr(CSR_COEF_D, COEF_D_RESET);
      send_point(24'd155189, -24'sd149264, 17'd0, 17'd65536);
      send_point(24'h400000, 24'hC00000, 17'd12345, 17'd54321);
      drain_results();

      // Random phases with swapped idle rates, then none
      random_phase(32);
      send_idle = 57;
      recv_idle = 27;
      random_phase(32);
      send_idle = 0;
      recv_idle = 0;
      write_csr(CSR_ITER_COUNT, 24'd4);
      hold_off = 3000;
      for (int n = 0; n < 12; n++)
         send_point(rand_coef(), rand_coef(), rand_start(), rand_start());
      drain_results();
      random_phase(24);

      // Longest run: zero coefficients pin every point in one bin
      write_csr(CSR_ITER_COUNT, 24'h00FFFF);
      write_csr(CSR_COEF_C, 24'h000000);
      write_csr(CSR_COEF_D, 24'h000000);
      send_point(24'h000000, 24'h000000, 17'd0, 17'd65536);
      drain_results();
      repeat (64) @(negedge clock);

      if (error_count == 0)
         $display("de_jong_map_histogram_peaks_unit test passed");
      else
         $display("de_jong_map_histogram_peaks_unit test failed");
      $finish;
   end

endmodule
